FILE: rtl/dcf_pkg.sv
// Package for the double to custom float converter: types, widths and helpers.
// No dependencies.
package dcf_pkg;

    localparam int DBL_FRAC = 52;
    localparam int DBL_EXP  = 11;
    localparam logic [10:0] DBL_EXP_ALL_ONES = 11'h7FF;
    localparam logic [11:0] DBL_BIAS = 12'd1023;

    localparam logic [0:0] CFG_TOTAL_WIDTH    = 1'b0;
    localparam logic [0:0] CFG_EXPONENT_WIDTH = 1'b1;

    typedef enum logic [1:0] {
        KIND_FINITE,
        KIND_ZERO,
        KIND_INF,
        KIND_NAN
    } kind_t;

    // Clamped format settings
    typedef struct packed {
        logic [6:0] t;
        logic [3:0] ew;
        logic [5:0] f;
    } fmt_t;

    // Stage 1 to stage 2: normalised operand
    typedef struct packed {
        fmt_t         fmt;
        kind_t        kind;
        logic         sign;
        logic [52:0]  m;
        logic signed [12:0] te;
    } s1_t;

    // Stage 2 to stage 3: exponent and fraction before packing
    typedef struct packed {
        fmt_t         fmt;
        kind_t        kind;
        logic         sign;
        logic         ovf;
        logic [10:0]  te;
        logic [63:0]  frac;
    } s2_t;

    function automatic logic [63:0] low_mask(input logic [6:0] n);
        logic [63:0] m;
        if (n >= 7'd64)
            m = '1;
        else
            m = (64'd1 << n[5:0]) - 64'd1;
        return m;
    endfunction

endpackage

FILE: rtl/dcf_if.sv
// Valid/ready channel interfaces for the converter.
// Depends on nothing.
interface dcf_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] double_bits;
    modport source  (output valid, output double_bits, input ready);
    modport sink    (input valid, input double_bits, output ready);
    modport monitor (input valid, input double_bits, input ready);
endinterface

interface dcf_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] packed_result;
    logic        overflowed;
    modport source  (output valid, output packed_result, output overflowed, input ready);
    modport sink    (input valid, input packed_result, input overflowed, output ready);
    modport monitor (input valid, input packed_result, input overflowed, input ready);
endinterface

interface dcf_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [6:0]  data;
    modport source  (output valid, output index, output data, input ready);
    modport sink    (input valid, input index, input data, output ready);
    modport monitor (input valid, input index, input data, input ready);
endinterface

FILE: rtl/dcf_unpack.sv
// Stage 1: clamp the format, classify and normalise the double operand.
// Depends on dcf_pkg.
module dcf_unpack import dcf_pkg::*;
(
    input  logic [6:0]  total_width,
    input  logic [3:0]  exponent_width,
    input  logic [63:0] double_bits,
    output s1_t         s1
);
    logic [6:0]  t;
    logic [3:0]  ew;
    logic [10:0] dexp;
    logic [51:0] dfrac;
    logic [5:0]  lz;
    logic [12:0] bias;
    logic signed [12:0] e;

    // Clamp the registers
    always_comb
    begin
        t = total_width;
        if (t < 7'd4) t = 7'd4;
        if (t > 7'd64) t = 7'd64;
        ew = exponent_width;
        if (ew < 4'd2) ew = 4'd2;
        if (ew > 4'd11) ew = 4'd11;
        if ({3'd0, ew} > t - 7'd2) ew = 4'(t - 7'd2);
    end

    // Count leading zeros of the fraction for double denormals
    always_comb
    begin
        lz = 6'd0;
        for (int i = 0; i < 52; i++)
        begin
            if (dfrac[i]) lz = 6'(51 - i);
        end
    end

    assign dexp  = double_bits[62:52];
    assign dfrac = double_bits[51:0];
    assign bias  = (13'd1 << (ew - 4'd1)) - 13'd1;

    always_comb
    begin
        s1.fmt.t  = t;
        s1.fmt.ew = ew;
        s1.fmt.f  = 6'(t - {3'd0, ew} - 7'd1);
        s1.sign   = double_bits[63];
        if (dexp == DBL_EXP_ALL_ONES)
            s1.kind = (dfrac != '0) ? KIND_NAN : KIND_INF;
        else if (dexp == '0 && dfrac == '0)
            s1.kind = KIND_ZERO;
        else
            s1.kind = KIND_FINITE;
        if (dexp == '0)
        begin
            s1.m = {1'b0, dfrac} << (lz + 6'd1);
            e    = -13'sd1023 - $signed({7'd0, lz});
        end
        else
        begin
            s1.m = {1'b1, dfrac};
            e    = $signed({2'd0, dexp}) - $signed({1'b0, DBL_BIAS});
        end
        s1.te = e + $signed(bias);
    end
endmodule

FILE: rtl/dcf_round.sv
// Stage 2: range check, denormal shift or rounding of the fraction.
// Depends on dcf_pkg.
module dcf_round import dcf_pkg::*;
(
    input  s1_t s1,
    output s2_t s2
);
    logic signed [12:0] expmax;
    logic signed [12:0] sh;
    logic [5:0]  k;
    logic [53:0] r;
    logic signed [12:0] te;
    logic [6:0]  f7;

    always_comb
    begin
        f7     = {1'b0, s1.fmt.f};
        expmax = $signed((13'd1 << s1.fmt.ew) - 13'd1);
        sh     = 13'sd53 - $signed({7'd0, s1.fmt.f}) - s1.te;
        k      = 6'd52 - s1.fmt.f;
        r      = 54'd0;
        te     = s1.te;
        s2.fmt  = s1.fmt;
        s2.kind = s1.kind;
        s2.sign = s1.sign;
        s2.ovf  = 1'b0;
        s2.frac = 64'd0;
        if (s1.te >= expmax)
        begin
            s2.ovf = 1'b1;
            te     = expmax;
        end
        else if (s1.te <= 0)
        begin
            // Truncated denormal
            if (sh >= 13'sd64)
                s2.frac = 64'd0;
            else if (sh >= 0)
                s2.frac = {11'd0, s1.m} >> sh[5:0];
            else
                s2.frac = {11'd0, s1.m} << 6'(-sh);
            te = 13'sd0;
        end
        else if (s1.fmt.f >= 6'd52)
        begin
            s2.frac = {12'd0, s1.m[51:0]} << (s1.fmt.f - 6'd52);
        end
        else
        begin
            // Round to nearest, ties away from zero
            r = ({1'b0, s1.m} >> k) + {53'd0, s1.m[k - 6'd1]};
            if ((r >> (f7 + 7'd1)) != '0)
            begin
                r  = r >> 1;
                te = te + 13'sd1;
            end
            if (te >= expmax)
            begin
                s2.ovf = 1'b1;
                te     = expmax;
            end
            else
                s2.frac = {10'd0, r} & low_mask(f7);
        end
        s2.te = te[10:0];
    end
endmodule

FILE: rtl/dcf_pack.sv
// Stage 3: assemble the target encoding, handle specials, place the sign.
// Depends on dcf_pkg.
module dcf_pack import dcf_pkg::*;
(
    input  s2_t         s2,
    output logic [63:0] packed_result,
    output logic        overflowed
);
    logic [63:0] res;
    logic [63:0] expmax;

    always_comb
    begin
        expmax = (64'd1 << s2.fmt.ew) - 64'd1;
        overflowed = 1'b0;
        unique case (s2.kind)
            KIND_NAN:    res = (expmax << s2.fmt.f) | (64'd1 << (s2.fmt.f - 6'd1));
            KIND_INF:    res = expmax << s2.fmt.f;
            KIND_ZERO:   res = 64'd0;
            default:
            begin
                res = ({53'd0, s2.te} << s2.fmt.f) | (s2.frac & low_mask({1'b0, s2.fmt.f}));
                overflowed = s2.ovf;
            end
        endcase
        res = res | ({63'd0, s2.sign} << (s2.fmt.t - 7'd1));
        packed_result = res & low_mask(s2.fmt.t);
    end
endmodule

FILE: rtl/double_to_custom_float_unit.sv
// Top level of the double to custom float converter: config registers and pipeline.
// Depends on dcf_pkg, dcf_if, dcf_unpack, dcf_round, dcf_pack.
//
// Converts one IEEE binary64 value per cycle into a sign/exponent/fraction format
// of total_width bits with exponent_width exponent bits, right aligned. The work is
// split over three register stages (unpack and normalise, round, pack): each result
// is registered in turn in s1_reg, s2_reg and res_reg before it is offered; every
// stage holds when the output stalls, and a new transaction is taken every cycle
// while the pipeline advances.
// Write configuration only while the pipeline is empty.
module double_to_custom_float_unit import dcf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    dcf_cfg_if.sink   cfg,
    dcf_in_if.sink    in_ch,
    dcf_out_if.source out_ch
);
    logic [6:0] total_width_reg;
    logic [3:0] exponent_width_reg;
    logic       v1_reg, v2_reg, v3_reg;
    s1_t        s1_next, s1_reg;
    s2_t        s2_next, s2_reg;
    logic [63:0] res_next, res_reg;
    logic       ovf_next, ovf_reg;
    logic       adv3, adv2, adv1;

    assign cfg.ready = 1'b1;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_width_reg    <= 7'd32;
            exponent_width_reg <= 4'd8;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == CFG_TOTAL_WIDTH)
                total_width_reg <= cfg.data;
            else
                exponent_width_reg <= cfg.data[3:0];
        end
    end

    // Advance each stage when the next one is free
    assign adv3 = !v3_reg || out_ch.ready;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign in_ch.ready = adv1;

    dcf_unpack u_unpack (
        .total_width    (total_width_reg),
        .exponent_width (exponent_width_reg),
        .double_bits    (in_ch.double_bits),
        .s1             (s1_next)
    );
    dcf_round u_round (.s1(s1_reg), .s2(s2_next));
    dcf_pack u_pack (.s2(s2_reg), .packed_result(res_next), .overflowed(ovf_next));

    // Move valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= in_ch.valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
        end
    end

    // Move payload
    always_ff @(posedge clk)
    begin
        if (adv1) s1_reg <= s1_next;
        if (adv2) s2_reg <= s2_next;
        if (adv3)
        begin
            res_reg <= res_next;
            ovf_reg <= ovf_next;
        end
    end

    assign out_ch.valid         = v3_reg;
    assign out_ch.packed_result = res_reg;
    assign out_ch.overflowed    = ovf_reg;
endmodule
